/* design/rjfp_pkg.sv */
// Package for the RPC frame parser: word types, configuration set and codes.
// Used by every module of the parser; it depends on nothing else.
package rjfp_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 16;
    localparam int POS_W       = 4;

    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam logic [POS_W-1:0] POS_SAT   = 4'd9;
    localparam logic [POS_W-1:0] POS_SHORT = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] REG_CALL_CHAR   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RESULT_CHAR = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_CHAR  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ID      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ACTION  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 3'd5;

    localparam logic [1:0] FLD_NONE    = 2'd0;
    localparam logic [1:0] FLD_ID      = 2'd1;
    localparam logic [1:0] FLD_ACTION  = 2'd2;
    localparam logic [1:0] FLD_PAYLOAD = 2'd3;

    localparam logic [1:0] KIND_UNKNOWN = 2'd0;
    localparam logic [1:0] KIND_CALL    = 2'd1;
    localparam logic [1:0] KIND_RESULT  = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] PH_QUOTE  = 2'd0;
    localparam logic [1:0] PH_STRING = 2'd1;
    localparam logic [1:0] PH_DELIM  = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_SHORT      = 4'd1;
    localparam logic [3:0] ST_BAD_OPEN   = 4'd2;
    localparam logic [3:0] ST_BAD_TYPE   = 4'd3;
    localparam logic [3:0] ST_COMMA      = 4'd4;
    localparam logic [3:0] ST_QUOTE      = 4'd5;
    localparam logic [3:0] ST_ID_LONG    = 4'd6;
    localparam logic [3:0] ST_DELIMITER  = 4'd7;
    localparam logic [3:0] ST_NO_PAYLOAD = 4'd8;
    localparam logic [3:0] ST_BAD_CLOSE  = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_message;
        logic       last_of_message;
    } in_word_t;

    typedef struct packed {
        logic       char_valid;
        logic [1:0] field_kind;
        logic [7:0] char_value;
        logic       field_done;
        logic       end_of_message;
        logic [1:0] message_kind;
        logic [3:0] status;
    } out_word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        logic       is_open;
        logic       is_close;
        logic       is_quote;
        logic       is_comma;
        logic [1:0] type_kind;
    } item_t;

    typedef struct packed {
        logic [7:0]         call_type_char;
        logic [7:0]         result_type_char;
        logic [7:0]         error_type_char;
        logic [7:0]         max_id_length;
        logic [7:0]         max_action_length;
        logic [COUNT_W-1:0] max_payload_length;
    } cfg_t;

endpackage

/* design/rpc_json_frame_parser_top.sv */
// Top level of the RPC frame parser for frames of the form [type,"id","action",payload].
// Holds the configuration registers and joins rjfp_front, rjfp_queue and rjfp_back.
//
// Usage: message words enter on s_valid/s_ready/s_data, one byte per word with its
// first and last flags. Each accepted word yields exactly one result word on
// m_valid/m_ready/m_data: a tagged field character, a field end, or, for the last
// word, the message kind and final status. Configuration is written through
// cfg_valid/cfg_ready/cfg_index/cfg_data while no message is in flight; cfg_ready
// is always high and indexes beyond the register list are ignored.
// An accepted input word passes through the classifier register, the queue, and the
// output register of the state machine, in that order, before it shows on m_valid.
// Throughput is one word per cycle while m_ready holds high, set by the state update
// of the back stage. When the receiver stalls, the output register holds, the queue fills,
// and s_ready falls once the classifier register cannot drain; no word is lost.
// Reset is synchronous and active low: it empties the queue, clears the parse
// state, and loads the configuration registers with their default values.
module rpc_json_frame_parser_top #(
    parameter int QUEUE_DEPTH = rjfp_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rjfp_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rjfp_pkg::out_word_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rjfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rjfp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rjfp_pkg::cfg_t  cfg_reg;
    logic            push_valid;
    logic            push_ready;
    rjfp_pkg::item_t push_item;
    logic            rd_valid;
    logic            rd_ready;
    rjfp_pkg::item_t rd_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.call_type_char     <= 8'd50;
            cfg_reg.result_type_char   <= 8'd51;
            cfg_reg.error_type_char    <= 8'd52;
            cfg_reg.max_id_length      <= 8'd36;
            cfg_reg.max_action_length  <= 8'd128;
            cfg_reg.max_payload_length <= 16'd255;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                rjfp_pkg::REG_CALL_CHAR:   cfg_reg.call_type_char    <= cfg_data[7:0];
                rjfp_pkg::REG_RESULT_CHAR: cfg_reg.result_type_char  <= cfg_data[7:0];
                rjfp_pkg::REG_ERROR_CHAR:  cfg_reg.error_type_char   <= cfg_data[7:0];
                rjfp_pkg::REG_MAX_ID:      cfg_reg.max_id_length     <= cfg_data[7:0];
                rjfp_pkg::REG_MAX_ACTION:  cfg_reg.max_action_length <= cfg_data[7:0];
                rjfp_pkg::REG_MAX_PAYLOAD: cfg_reg.max_payload_length <= cfg_data;
                default: ;
            endcase
        end
    end

    rjfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    rjfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_item  (rd_item)
    );

    rjfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_item  (rd_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* design/rjfp_front.sv */
// Front stage of the RPC frame parser: accepts input words and classifies them.
// Depends on rjfp_pkg; feeds rjfp_queue.
module rjfp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  rjfp_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  rjfp_pkg::in_word_t s_data,
    output logic              push_valid,
    input  logic              push_ready,
    output rjfp_pkg::item_t   push_item
);

    logic            valid_reg;
    rjfp_pkg::item_t item_reg;
    rjfp_pkg::item_t item_next;

    assign s_ready    = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb begin
        item_next.data_byte = s_data.data_byte;
        item_next.first     = s_data.first_of_message;
        item_next.last      = s_data.last_of_message;
        item_next.is_open   = (s_data.data_byte == rjfp_pkg::CH_OPEN);
        item_next.is_close  = (s_data.data_byte == rjfp_pkg::CH_CLOSE);
        item_next.is_quote  = (s_data.data_byte == rjfp_pkg::CH_QUOTE);
        item_next.is_comma  = (s_data.data_byte == rjfp_pkg::CH_COMMA);
        priority if (s_data.data_byte == cfg.call_type_char) begin
            item_next.type_kind = rjfp_pkg::KIND_CALL;
        end else if (s_data.data_byte == cfg.result_type_char) begin
            item_next.type_kind = rjfp_pkg::KIND_RESULT;
        end else if (s_data.data_byte == cfg.error_type_char) begin
            item_next.type_kind = rjfp_pkg::KIND_ERROR;
        end else begin
            item_next.type_kind = rjfp_pkg::KIND_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

/* design/rjfp_queue.sv */
// Short queue of classified words between the front and back of the parser.
// Depends on rjfp_pkg.
module rjfp_queue #(
    parameter int DEPTH = rjfp_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rjfp_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rjfp_pkg::item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rjfp_pkg::item_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

/* design/rjfp_back.sv */
// Back stage of the RPC frame parser: frame state machine and output register.
// Depends on rjfp_pkg; takes words from rjfp_queue.
module rjfp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  rjfp_pkg::cfg_t     cfg,
    input  logic               rd_valid,
    output logic               rd_ready,
    input  rjfp_pkg::item_t    rd_item,
    output logic               m_valid,
    input  logic               m_ready,
    output rjfp_pkg::out_word_t m_data
);

    localparam int CW = rjfp_pkg::COUNT_W;
    localparam int PW = rjfp_pkg::POS_W;

    logic [PW-1:0] pos_reg, pos_next, e_pos;
    logic [1:0]    phase_reg, phase_next, e_phase;
    logic [1:0]    field_reg, field_next, e_field;
    logic [CW-1:0] count_reg, count_next, e_count;
    logic [1:0]    kind_reg, kind_next, e_kind;
    logic [3:0]    err_reg, err_next, e_err;
    logic          inpay_reg, inpay_next, e_inpay;
    logic [CW-1:0] limit;
    logic          pop;
    logic          out_valid_reg;
    rjfp_pkg::out_word_t out_reg, out_next;

    assign rd_ready = !out_valid_reg || m_ready;
    assign pop      = rd_valid && rd_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    always_comb begin
        if (rd_item.first) begin
            e_pos   = '0;
            e_phase = rjfp_pkg::PH_QUOTE;
            e_field = rjfp_pkg::FLD_ID;
            e_count = '0;
            e_kind  = rjfp_pkg::KIND_UNKNOWN;
            e_err   = rjfp_pkg::ST_OK;
            e_inpay = 1'b0;
        end else begin
            e_pos   = pos_reg;
            e_phase = phase_reg;
            e_field = field_reg;
            e_count = count_reg;
            e_kind  = kind_reg;
            e_err   = err_reg;
            e_inpay = inpay_reg;
        end

        unique case (e_field)
            rjfp_pkg::FLD_ID:     limit = CW'(cfg.max_id_length);
            rjfp_pkg::FLD_ACTION: limit = CW'(cfg.max_action_length);
            default:              limit = '0;
        endcase

        pos_next   = e_pos;
        phase_next = e_phase;
        field_next = e_field;
        count_next = e_count;
        kind_next  = e_kind;
        err_next   = e_err;
        inpay_next = e_inpay;
        out_next   = '0;

        if (rd_item.last) begin
            out_next.end_of_message = 1'b1;
            out_next.message_kind   = e_kind;
            priority if (e_pos < rjfp_pkg::POS_SHORT) begin
                out_next.status = rjfp_pkg::ST_SHORT;
            end else if (e_err == rjfp_pkg::ST_BAD_OPEN) begin
                out_next.status = rjfp_pkg::ST_BAD_OPEN;
            end else if (!rd_item.is_close) begin
                out_next.status = rjfp_pkg::ST_BAD_CLOSE;
            end else if (e_err != rjfp_pkg::ST_OK) begin
                out_next.status = e_err;
            end else if (e_field != rjfp_pkg::FLD_PAYLOAD) begin
                out_next.status = rjfp_pkg::ST_NO_PAYLOAD;
            end else begin
                out_next.status = rjfp_pkg::ST_OK;
            end
            pos_next   = '0;
            phase_next = rjfp_pkg::PH_QUOTE;
            field_next = rjfp_pkg::FLD_ID;
            count_next = '0;
            kind_next  = rjfp_pkg::KIND_UNKNOWN;
            err_next   = rjfp_pkg::ST_OK;
            inpay_next = 1'b0;
        end else begin
            priority if (e_err != rjfp_pkg::ST_OK) begin
                err_next = e_err;
            end else if (e_pos == PW'(0)) begin
                if (!rd_item.is_open) begin
                    err_next = rjfp_pkg::ST_BAD_OPEN;
                end
            end else if (e_pos == PW'(1)) begin
                if (rd_item.type_kind == rjfp_pkg::KIND_UNKNOWN) begin
                    err_next = rjfp_pkg::ST_BAD_TYPE;
                end else begin
                    kind_next = rd_item.type_kind;
                end
            end else if (e_pos == PW'(2)) begin
                if (!rd_item.is_comma) begin
                    err_next = rjfp_pkg::ST_COMMA;
                end else begin
                    field_next = rjfp_pkg::FLD_ID;
                    count_next = '0;
                    phase_next = rjfp_pkg::PH_QUOTE;
                end
            end else if (e_inpay) begin
                if (e_count < cfg.max_payload_length) begin
                    count_next            = e_count + CW'(1);
                    out_next.char_valid   = 1'b1;
                    out_next.field_kind   = rjfp_pkg::FLD_PAYLOAD;
                    out_next.char_value   = rd_item.data_byte;
                end
            end else if (e_phase == rjfp_pkg::PH_QUOTE) begin
                if (!rd_item.is_quote) begin
                    err_next = rjfp_pkg::ST_QUOTE;
                end else begin
                    phase_next = rjfp_pkg::PH_STRING;
                end
            end else if (e_phase == rjfp_pkg::PH_STRING) begin
                if (rd_item.is_quote) begin
                    out_next.field_done = 1'b1;
                    out_next.field_kind = e_field;
                    phase_next          = rjfp_pkg::PH_DELIM;
                    if (e_kind != rjfp_pkg::KIND_ERROR) begin
                        count_next = '0;
                        if (e_kind == rjfp_pkg::KIND_CALL
                                && e_field == rjfp_pkg::FLD_ID) begin
                            field_next = rjfp_pkg::FLD_ACTION;
                        end else if (e_kind == rjfp_pkg::KIND_CALL
                                && e_field == rjfp_pkg::FLD_ACTION) begin
                            field_next = rjfp_pkg::FLD_PAYLOAD;
                        end else if (e_kind == rjfp_pkg::KIND_RESULT
                                && e_field == rjfp_pkg::FLD_ID) begin
                            field_next = rjfp_pkg::FLD_PAYLOAD;
                        end else begin
                            field_next = rjfp_pkg::FLD_NONE;
                        end
                    end
                end else if (e_count < limit) begin
                    count_next          = e_count + CW'(1);
                    out_next.char_valid = 1'b1;
                    out_next.field_kind = e_field;
                    out_next.char_value = rd_item.data_byte;
                end else if (e_field == rjfp_pkg::FLD_ID) begin
                    err_next = rjfp_pkg::ST_ID_LONG;
                end
            end else if (e_phase == rjfp_pkg::PH_DELIM) begin
                priority if (!rd_item.is_comma) begin
                    err_next = rjfp_pkg::ST_DELIMITER;
                end else if (e_field == rjfp_pkg::FLD_PAYLOAD) begin
                    inpay_next = 1'b1;
                end else if (e_field == rjfp_pkg::FLD_NONE) begin
                    phase_next = rjfp_pkg::PH_STOP;
                end else begin
                    phase_next = rjfp_pkg::PH_QUOTE;
                end
            end else begin
                phase_next = e_phase;
            end
            if (e_pos < rjfp_pkg::POS_SAT) begin
                pos_next = e_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            phase_reg     <= rjfp_pkg::PH_QUOTE;
            field_reg     <= rjfp_pkg::FLD_ID;
            count_reg     <= '0;
            kind_reg      <= rjfp_pkg::KIND_UNKNOWN;
            err_reg       <= rjfp_pkg::ST_OK;
            inpay_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                field_reg <= field_next;
                count_reg <= count_next;
                kind_reg  <= kind_next;
                err_reg   <= err_next;
                inpay_reg <= inpay_next;
            end
            if (rd_ready) begin
                out_valid_reg <= rd_valid;
            end
        end
        if (pop) begin
            out_reg <= out_next;
        end
    end

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= rjfp_pkg::POS_SAT)
        else $error("byte position ran past its saturation value");

    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.end_of_message) |->
            (out_reg.status == rjfp_pkg::ST_OK
             && out_reg.message_kind == rjfp_pkg::KIND_UNKNOWN))
        else $error("status or message kind reported before the last word");

    a_no_char_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.end_of_message) |->
            (!out_reg.char_valid && !out_reg.field_done))
        else $error("last word reported as a field character");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && rd_item.last) |=>
            (pos_reg == '0 && err_reg == rjfp_pkg::ST_OK && !inpay_reg))
        else $error("parser state not restarted after the last word");

    a_payload_field: assert property (@(posedge aclk) disable iff (!aresetn)
        inpay_reg |-> (field_reg == rjfp_pkg::FLD_PAYLOAD))
        else $error("payload scan active outside the payload field");

endmodule

/* dv/rpc_json_frame_parser_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rpc_json_frame_parser_top: directed frames, then random frames
// in several register settings; each result word matched to an in-bench model or fixed word.
// Depends only on rjfp_pkg and the parser RTL.
module rpc_json_frame_parser_top_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 206;
    localparam int END_SETTLE = 16;
    localparam logic [rjfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [rjfp_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        rjfp_pkg::in_word_t  w;
        bit                  typed;
        rjfp_pkg::out_word_t want;
    } stim_row_t;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    rjfp_pkg::in_word_t               s_data;
    logic                             m_valid;
    logic                             m_ready;
    rjfp_pkg::out_word_t              m_data;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [rjfp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rjfp_pkg::CFG_DATA_W-1:0]  cfg_data;

    rjfp_pkg::cfg_t               model_cfg;
    logic [rjfp_pkg::POS_W-1:0]   frame_pos;
    logic [1:0]                   scan_ph;
    logic [1:0]                   cur_field;
    logic [rjfp_pkg::COUNT_W-1:0] field_len;
    logic [1:0]                   held_kind;
    logic [3:0]                   held_err;
    logic                         payload_on;

    rjfp_pkg::out_word_t expected_words[$];
    rjfp_pkg::in_word_t  frame_q[$];
    stim_row_t           stim_rows[$];
    int                  live_items;
    int                  burst_left;
    bit                  gapless;
    bit                  rand_started;
    int                  mismatches;
    int                  cycle_count;

    rpc_json_frame_parser_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void restart_parse();
        frame_pos  = '0;
        scan_ph    = rjfp_pkg::PH_QUOTE;
        cur_field  = rjfp_pkg::FLD_ID;
        field_len  = '0;
        held_kind  = rjfp_pkg::KIND_UNKNOWN;
        held_err   = rjfp_pkg::ST_OK;
        payload_on = 1'b0;
    endfunction

    function automatic rjfp_pkg::out_word_t parse_byte(rjfp_pkg::in_word_t w);
        rjfp_pkg::out_word_t          r;
        logic [7:0]                   d;
        logic [rjfp_pkg::COUNT_W-1:0] cap;
        r = '0;
        d = w.data_byte;
        if (w.first_of_message) restart_parse();
        if (w.last_of_message) begin
            r.end_of_message = 1'b1;
            r.message_kind = held_kind;
            if (frame_pos < rjfp_pkg::POS_SHORT) r.status = rjfp_pkg::ST_SHORT;
            else if (held_err == rjfp_pkg::ST_BAD_OPEN) r.status = rjfp_pkg::ST_BAD_OPEN;
            else if (d != rjfp_pkg::CH_CLOSE) r.status = rjfp_pkg::ST_BAD_CLOSE;
            else if (held_err != rjfp_pkg::ST_OK) r.status = held_err;
            else if (cur_field != rjfp_pkg::FLD_PAYLOAD) r.status = rjfp_pkg::ST_NO_PAYLOAD;
            else r.status = rjfp_pkg::ST_OK;
            restart_parse();
            return r;
        end
        if (held_err != rjfp_pkg::ST_OK) begin
            r = '0;
        end else if (frame_pos == 0) begin
            if (d != rjfp_pkg::CH_OPEN) held_err = rjfp_pkg::ST_BAD_OPEN;
        end else if (frame_pos == 1) begin
            if (d == model_cfg.call_type_char) held_kind = rjfp_pkg::KIND_CALL;
            else if (d == model_cfg.result_type_char) held_kind = rjfp_pkg::KIND_RESULT;
            else if (d == model_cfg.error_type_char) held_kind = rjfp_pkg::KIND_ERROR;
            else held_err = rjfp_pkg::ST_BAD_TYPE;
        end else if (frame_pos == 2) begin
            if (d != rjfp_pkg::CH_COMMA) begin
                held_err = rjfp_pkg::ST_COMMA;
            end else begin
                cur_field = rjfp_pkg::FLD_ID;
                field_len = '0;
                scan_ph = rjfp_pkg::PH_QUOTE;
            end
        end else if (payload_on) begin
            if (field_len < model_cfg.max_payload_length) begin
                field_len++;
                r.char_valid = 1'b1;
                r.field_kind = rjfp_pkg::FLD_PAYLOAD;
                r.char_value = d;
            end
        end else if (scan_ph == rjfp_pkg::PH_QUOTE) begin
            if (d != rjfp_pkg::CH_QUOTE) held_err = rjfp_pkg::ST_QUOTE;
            else scan_ph = rjfp_pkg::PH_STRING;
        end else if (scan_ph == rjfp_pkg::PH_STRING) begin
            if (d == rjfp_pkg::CH_QUOTE) begin
                r.field_done = 1'b1;
                r.field_kind = cur_field;
                // An error frame keeps the id field and its count across strings.
                if (held_kind != rjfp_pkg::KIND_ERROR) begin
                    if (held_kind == rjfp_pkg::KIND_CALL && cur_field == rjfp_pkg::FLD_ID)
                        cur_field = rjfp_pkg::FLD_ACTION;
                    else if (held_kind == rjfp_pkg::KIND_CALL
                             && cur_field == rjfp_pkg::FLD_ACTION)
                        cur_field = rjfp_pkg::FLD_PAYLOAD;
                    else if (held_kind == rjfp_pkg::KIND_RESULT
                             && cur_field == rjfp_pkg::FLD_ID)
                        cur_field = rjfp_pkg::FLD_PAYLOAD;
                    else cur_field = rjfp_pkg::FLD_NONE;
                    field_len = '0;
                end
                scan_ph = rjfp_pkg::PH_DELIM;
            end else begin
                cap = (cur_field == rjfp_pkg::FLD_ID) ? {8'd0, model_cfg.max_id_length}
                    : (cur_field == rjfp_pkg::FLD_ACTION)
                        ? {8'd0, model_cfg.max_action_length} : '0;
                if (field_len < cap) begin
                    field_len++;
                    r.char_valid = 1'b1;
                    r.field_kind = cur_field;
                    r.char_value = d;
                end else if (cur_field == rjfp_pkg::FLD_ID) begin
                    held_err = rjfp_pkg::ST_ID_LONG;
                end
            end
        end else if (scan_ph == rjfp_pkg::PH_DELIM) begin
            if (d != rjfp_pkg::CH_COMMA) held_err = rjfp_pkg::ST_DELIMITER;
            else if (cur_field == rjfp_pkg::FLD_PAYLOAD) payload_on = 1'b1;
            else if (cur_field == rjfp_pkg::FLD_NONE) scan_ph = rjfp_pkg::PH_STOP;
            else scan_ph = rjfp_pkg::PH_QUOTE;
        end
        if (frame_pos < rjfp_pkg::POS_SAT) frame_pos++;
        return r;
    endfunction

    function automatic rjfp_pkg::out_word_t status_word(logic [1:0] kind, logic [3:0] st);
        rjfp_pkg::out_word_t r;
        r = '0;
        r.end_of_message = 1'b1;
        r.message_kind = kind;
        r.status = st;
        return r;
    endfunction

    function automatic int next_gap();
        if (gapless) return 0;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 30);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom);
        if (c == rjfp_pkg::CH_QUOTE) c = rjfp_pkg::CH_QUOTE + 8'd1;
        return c;
    endfunction

    function automatic int pick_len(int cap, int extra);
        int r;
        r = $urandom_range(0, 19);
        if (cap > 40 && $urandom_range(0, 7) != 0) r = 5;
        if (r == 0) return cap + extra;
        if (r == 1) return cap;
        return $urandom_range(0, (cap < 6) ? cap : 6);
    endfunction

    task automatic add_row(logic [7:0] d, bit first, bit last, bit typed,
                           rjfp_pkg::out_word_t want);
        stim_row_t row;
        row.w.data_byte = d;
        row.w.first_of_message = first;
        row.w.last_of_message = last;
        row.typed = typed;
        row.want = want;
        stim_rows.push_back(row);
    endtask

    task automatic add_byte(logic [7:0] d);
        rjfp_pkg::in_word_t w;
        w.data_byte = d;
        w.first_of_message = 1'b0;
        w.last_of_message = 1'b0;
        frame_q.push_back(w);
    endtask

    task automatic build_frame();
        int                 sel;
        int                 nstr;
        int                 len;
        int                 cap;
        int                 i;
        int                 cut;
        logic [7:0]         tchar;
        rjfp_pkg::in_word_t w;
        frame_q.delete();
        sel = $urandom_range(0, 19);
        if (sel < 2) begin
            repeat ($urandom_range(1, 4)) begin
                w.data_byte = 8'($urandom);
                w.first_of_message = 1'($urandom_range(0, 1));
                w.last_of_message = 1'($urandom_range(0, 1));
                frame_q.push_back(w);
            end
            return;
        end
        if (sel < 10) begin
            tchar = model_cfg.call_type_char;
            nstr = 2;
        end else if (sel < 15) begin
            tchar = model_cfg.result_type_char;
            nstr = 1;
        end else if (sel < 18) begin
            tchar = model_cfg.error_type_char;
            nstr = $urandom_range(1, 2);
        end else begin
            tchar = 8'($urandom);
            nstr = $urandom_range(0, 2);
        end
        add_byte(rjfp_pkg::CH_OPEN);
        add_byte(tchar);
        add_byte(rjfp_pkg::CH_COMMA);
        for (i = 0; i < nstr; i++) begin
            cap = (i == 0) ? int'(model_cfg.max_id_length) : int'(model_cfg.max_action_length);
            len = pick_len(cap, (i == 0) ? 1 : 3);
            add_byte(rjfp_pkg::CH_QUOTE);
            repeat (len) add_byte(text_char());
            add_byte(rjfp_pkg::CH_QUOTE);
            add_byte(rjfp_pkg::CH_COMMA);
        end
        cap = int'(model_cfg.max_payload_length);
        len = (cap <= 24 && $urandom_range(0, 3) == 0) ? cap + 2 : $urandom_range(0, 10);
        repeat (len) add_byte(8'($urandom));
        add_byte(rjfp_pkg::CH_CLOSE);
        w = frame_q[frame_q.size() - 1];
        w.last_of_message = 1'b1;
        frame_q[frame_q.size() - 1] = w;
        w = frame_q[0];
        w.first_of_message = ($urandom_range(0, 9) != 0);
        frame_q[0] = w;
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(0, frame_q.size() - 1);
            w = frame_q[cut];
            w.data_byte = 8'($urandom);
            frame_q[cut] = w;
        end
        if ($urandom_range(0, 11) == 0) begin
            cut = $urandom_range(0, frame_q.size() - 1);
            while (frame_q.size() > cut + 1) void'(frame_q.pop_back());
            w = frame_q[cut];
            w.last_of_message = 1'b1;
            frame_q[cut] = w;
        end else if ($urandom_range(0, 24) == 0) begin
            w = frame_q[frame_q.size() - 1];
            w.last_of_message = 1'b0;
            frame_q[frame_q.size() - 1] = w;
        end
    endtask

    task automatic send_word(rjfp_pkg::in_word_t w, int gap, bit typed,
                             rjfp_pkg::out_word_t want);
        rjfp_pkg::out_word_t predicted;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = parse_byte(w);
        expected_words.push_back(typed ? want : predicted);
        live_items++;
    endtask

    task automatic drain_words();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [rjfp_pkg::CFG_INDEX_W-1:0] idx,
                             logic [rjfp_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            rjfp_pkg::REG_CALL_CHAR:   model_cfg.call_type_char = val[7:0];
            rjfp_pkg::REG_RESULT_CHAR: model_cfg.result_type_char = val[7:0];
            rjfp_pkg::REG_ERROR_CHAR:  model_cfg.error_type_char = val[7:0];
            rjfp_pkg::REG_MAX_ID:      model_cfg.max_id_length = val[7:0];
            rjfp_pkg::REG_MAX_ACTION:  model_cfg.max_action_length = val[7:0];
            rjfp_pkg::REG_MAX_PAYLOAD: model_cfg.max_payload_length = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_phase(int ph);
        logic [7:0]  c;
        logic [7:0]  r;
        logic [7:0]  e;
        logic [7:0]  id_max;
        logic [7:0]  act_max;
        logic [15:0] pay_max;
        case (ph)
            1: begin
                c = 8'h00; r = 8'hFF; e = 8'h80;
                id_max = 8'd1; act_max = 8'd1; pay_max = 16'd0;
            end
            2: begin
                c = 8'hFF; r = 8'hFF; e = 8'hFF;
                id_max = 8'd255; act_max = 8'd255; pay_max = 16'hFFFF;
            end
            3: begin
                c = 8'($urandom); r = 8'($urandom); e = r;
                id_max = 8'($urandom_range(1, 8)); act_max = 8'($urandom_range(1, 8));
                pay_max = 16'($urandom_range(0, 12));
            end
            default: begin
                c = 8'($urandom); r = 8'($urandom); e = 8'($urandom);
                id_max = 8'($urandom_range(1, 16)); act_max = 8'($urandom_range(1, 16));
                pay_max = 16'($urandom_range(0, 24));
            end
        endcase
        write_reg(rjfp_pkg::REG_CALL_CHAR, {8'($urandom), c});
        write_reg(rjfp_pkg::REG_RESULT_CHAR, {8'($urandom), r});
        write_reg(rjfp_pkg::REG_ERROR_CHAR, {8'($urandom), e});
        write_reg(rjfp_pkg::REG_MAX_ID, {8'($urandom), id_max});
        write_reg(rjfp_pkg::REG_MAX_ACTION, {8'($urandom), act_max});
        write_reg(rjfp_pkg::REG_MAX_PAYLOAD, pay_max);
        if (ph == 4) begin
            write_reg(REG_SPARE_LO, 16'($urandom));
            write_reg(REG_SPARE_HI, 16'($urandom));
        end
    endtask

    always @(posedge aclk) begin : result_check
        rjfp_pkg::out_word_t want;
        if (m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("%0t: result word with none expected: %h",
                                               $realtime, m_data);
            end else begin
                want = expected_words.pop_front();
                if (m_data.char_valid !== want.char_valid ||
                    m_data.field_kind !== want.field_kind ||
                    m_data.char_value !== want.char_value ||
                    m_data.field_done !== want.field_done ||
                    m_data.end_of_message !== want.end_of_message ||
                    m_data.message_kind !== want.message_kind ||
                    m_data.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display(
                            "%0t: expected cv=%b fk=%0d ch=%h fd=%b eom=%b mk=%0d st=%0d",
                            $realtime, want.char_valid, want.field_kind, want.char_value,
                            want.field_done, want.end_of_message, want.message_kind,
                            want.status);
                        $display(
                            "%0t: actual   cv=%b fk=%0d ch=%h fd=%b eom=%b mk=%0d st=%0d",
                            $realtime, m_data.char_valid, m_data.field_kind,
                            m_data.char_value, m_data.field_done, m_data.end_of_message,
                            m_data.message_kind, m_data.status);
                    end
                end
            end
        end
    end

    initial begin : result_stall
        int mode;
        int stretch;
        int hold;
        int tick;
        int warmup;
        bit long_done;
        mode = 0;
        stretch = 0;
        hold = 0;
        tick = 0;
        warmup = 0;
        long_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (!long_done && rand_started) begin
                warmup++;
                if (warmup == 40) begin
                    hold = 400;
                    long_done = 1'b1;
                end
            end
            if (hold == 0 && stretch == 0) begin
                mode = $urandom_range(0, 9);
                stretch = $urandom_range(20, 200);
                if (mode == 9) hold = $urandom_range(30, 90);
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                stretch--;
                case (mode)
                    0, 1, 2: m_ready <= 1'b1;
                    3, 4:    m_ready <= 1'($urandom_range(0, 1));
                    5, 6:    m_ready <= ($urandom_range(0, 7) != 0);
                    7:       m_ready <= (tick % 3 != 0);
                    default: m_ready <= (tick % 8 < 2);
                endcase
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int ph;
        int target;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        mismatches = 0;
        live_items = 0;
        burst_left = 0;
        gapless = 1'b0;
        rand_started = 1'b0;
        model_cfg.call_type_char = 8'd50;
        model_cfg.result_type_char = 8'd51;
        model_cfg.error_type_char = 8'd52;
        model_cfg.max_id_length = 8'd36;
        model_cfg.max_action_length = 8'd128;
        model_cfg.max_payload_length = 16'd255;
        restart_parse();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_row(rjfp_pkg::CH_OPEN, 1'b1, 1'b0, 1'b1, '0);
        add_row("2", 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_COMMA, 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
        add_row("a", 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_COMMA, 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
        add_row("B", 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_COMMA, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_CLOSE, 1'b0, 1'b1, 1'b1,
                status_word(rjfp_pkg::KIND_CALL, rjfp_pkg::ST_OK));
        add_row(8'hFF, 1'b1, 1'b1, 1'b1,
                status_word(rjfp_pkg::KIND_UNKNOWN, rjfp_pkg::ST_SHORT));
        // The next frame restarts on its own, with no first flag.
        add_row(rjfp_pkg::CH_OPEN, 1'b0, 1'b0, 1'b0, '0);
        add_row("3", 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_COMMA, 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_QUOTE, 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_COMMA, 1'b0, 1'b0, 1'b0, '0);
        add_row("1", 1'b0, 1'b0, 1'b0, '0);
        add_row("2", 1'b0, 1'b0, 1'b0, '0);
        add_row(rjfp_pkg::CH_CLOSE, 1'b0, 1'b1, 1'b1,
                status_word(rjfp_pkg::KIND_RESULT, rjfp_pkg::ST_OK));
        foreach (stim_rows[i])
            send_word(stim_rows[i].w, next_gap(), stim_rows[i].typed, stim_rows[i].want);
        drain_words();

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) program_phase(ph);
            gapless = (ph == 5);
            rand_started = 1'b1;
            target = live_items + PHASE_ITEMS;
            while (live_items < target) begin
                build_frame();
                foreach (frame_q[k]) send_word(frame_q[k], next_gap(), 1'b0, '0);
            end
            drain_words();
        end

        repeat (END_SETTLE) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
